/* design/nrgw_pkg.sv */
`default_nettype none

package nrgw_pkg;

    // Field widths
    localparam int RATE_W    = 17;
    localparam int GAIN_W    = 9;
    localparam int SMP_W     = 16;
    localparam int OUT_W     = 24;
    localparam int PROD_W    = SMP_W + GAIN_W + 1;
    localparam int PHASE_W   = 18;
    localparam int IDX_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int WC_MAX_W  = 17;

    // Parameter defaults
    localparam int RING_DEPTH_DEF = 8192;
    localparam int MAX_EMIT_DEF   = 8;

    // Register reset values
    localparam logic [RATE_W-1:0] IN_RATE_RST  = RATE_W'(22050);
    localparam logic [RATE_W-1:0] OUT_RATE_RST = RATE_W'(22050);
    localparam logic [GAIN_W-1:0] GAIN_RST     = GAIN_W'(256);

    // Saturation limits
    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_RATE  = 3'd0,
        CFG_OUT_RATE = 3'd1,
        CFG_GAIN     = 3'd2,
        CFG_STEREO   = 3'd3,
        CFG_WIDE     = 3'd4
    } cfg_idx_t;

    // Divider result bundle
    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quotient;
        logic [RATE_W-1:0] remainder;
    } div_res_t;

endpackage

`default_nettype wire

/* design/nrgw_divider.sv */
`default_nettype none

module nrgw_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [nrgw_pkg::RATE_W-1:0] dividend,
    input  wire logic [nrgw_pkg::RATE_W-1:0] divisor,
    output nrgw_pkg::div_res_t               res
);
    import nrgw_pkg::*;

    localparam int CNT_W = $clog2(RATE_W);

    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RATE_W-1:0] rem_reg,  rem_next;
    logic [RATE_W-1:0] quo_reg,  quo_next;
    logic [RATE_W-1:0] div_reg,  div_next;

    logic [RATE_W:0]   trial;
    logic [RATE_W:0]   diff;
    logic              fits;

    // One restoring step: bring down the next dividend bit, try the subtract
    assign trial = {rem_reg, quo_reg[RATE_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(RATE_W - 1);
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            quo_next = {quo_reg[RATE_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            div_reg  <= div_next;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

`default_nettype wire

/* design/nrgw_scale.sv */
`default_nettype none

module nrgw_scale (
    input  wire logic [nrgw_pkg::SMP_W-1:0]  raw,
    input  wire logic                        wide,
    input  wire logic [nrgw_pkg::GAIN_W-1:0] gain,
    output logic      [nrgw_pkg::OUT_W-1:0]  scaled
);
    import nrgw_pkg::*;

    logic signed [SMP_W-1:0]  smp;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod;
    logic                     ovf;

    // 8-bit unsigned: flip the top bit to recenter, shift up by a byte
    assign smp    = wide ? raw : {~raw[7], raw[6:0], 8'h00};
    assign gain_s = {1'b0, gain};
    assign prod   = smp * gain_s;

    // Saturate to the output width when the upper bits disagree
    assign ovf = (prod[PROD_W-1:OUT_W-1] != '0) && (prod[PROD_W-1:OUT_W-1] != '1);

    always_comb
    begin
        if (ovf)
            scaled = prod[PROD_W-1] ? SAT_MIN : SAT_MAX;
        else
            scaled = prod[OUT_W-1:0];
    end

endmodule

`default_nettype wire

/* design/nearest_resample_gain_ring_writer.sv */
`default_nettype none
// Flow: an accepted item that yields results moves to ST_DIV, where the
// single 17-step restoring divider counts its results, then to ST_EMIT,
// which loads one result per output handshake (up to MAX_EMIT); in_stall
// holds new items off until ST_IDLE. An item with no result only updates the phase.
// Reset: asynchronous, active low; registers return to their defaults,
// phase and ring write index clear to zero. No clearing pass.

module nearest_resample_gain_ring_writer #(
    parameter int RING_DEPTH = nrgw_pkg::RING_DEPTH_DEF,
    parameter int MAX_EMIT   = nrgw_pkg::MAX_EMIT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input items
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [nrgw_pkg::SMP_W-1:0]    left_raw,
    input  wire logic [nrgw_pkg::SMP_W-1:0]    right_raw,
    input  wire logic                          block_end,
    // result items
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [nrgw_pkg::OUT_W-1:0]  left_out,
    output logic signed [nrgw_pkg::OUT_W-1:0]  right_out,
    output logic      [nrgw_pkg::IDX_W-1:0]    ring_index,
    output logic                               run_last,
    output logic                               capped,
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [nrgw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nrgw_pkg::RATE_W-1:0]   cfg_data
);
    import nrgw_pkg::*;

    localparam int WC_W = $clog2(RING_DEPTH);
    localparam int EW   = $clog2(MAX_EMIT + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t             state_reg,      state_next;
    logic [RATE_W-1:0]  in_rate_reg,    in_rate_next;
    logic [RATE_W-1:0]  out_rate_reg,   out_rate_next;
    logic [GAIN_W-1:0]  gain_reg,       gain_next;
    logic               stereo_reg,     stereo_next;
    logic               wide_reg,       wide_next;
    logic [PHASE_W-1:0] phase_reg,      phase_next;
    logic [WC_W-1:0]    wc_reg,         wc_next;
    logic [SMP_W-1:0]   left_raw_reg,   left_raw_next;
    logic [SMP_W-1:0]   right_raw_reg,  right_raw_next;
    logic               blk_end_reg,    blk_end_next;
    logic               scale_sel_reg,  scale_sel_next;
    logic [OUT_W-1:0]   left_smp_reg,   left_smp_next;
    logic [OUT_W-1:0]   right_smp_reg,  right_smp_next;
    logic [EW-1:0]      emit_total_reg, emit_total_next;
    logic [EW-1:0]      emit_idx_reg,   emit_idx_next;
    logic               capped_reg,     capped_next;
    logic               out_valid_reg,  out_valid_next;
    logic [OUT_W-1:0]   left_out_reg,   left_out_next;
    logic [OUT_W-1:0]   right_out_reg,  right_out_next;
    logic [IDX_W-1:0]   ring_idx_reg,   ring_idx_next;
    logic               run_last_reg,   run_last_next;
    logic               out_cap_reg,    out_cap_next;

    logic [RATE_W-1:0]  ir;
    logic [RATE_W-1:0]  orate;
    logic               acc_lt;
    logic [PHASE_W-1:0] div_num_full;
    logic               in_fire;
    logic               div_start;
    div_res_t           div_res;
    logic [SMP_W-1:0]   scale_raw;
    logic [OUT_W-1:0]   scale_out;
    logic [PHASE_W-1:0] count;
    logic               count_cap;
    logic               load_out;
    logic [WC_MAX_W-1:0] wc_wide;

    // Zero rates count as one
    assign ir     = (in_rate_reg  == '0) ? RATE_W'(1) : in_rate_reg;
    assign orate  = (out_rate_reg == '0) ? RATE_W'(1) : out_rate_reg;
    assign acc_lt = (phase_reg < {1'b0, orate});

    // outputs before the next input: ceil((orate - acc) / ir) = (orate - acc - 1) / ir + 1
    assign div_num_full = {1'b0, orate} - phase_reg - PHASE_W'(1);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign div_start = in_fire && acc_lt;
    assign cfg_ready = 1'b1;

    nrgw_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num_full[RATE_W-1:0]),
        .divisor  (ir),
        .res      (div_res)
    );

    // One gain multiplier, left on the first divide cycle, right afterwards if stereo
    assign scale_raw = scale_sel_reg ? right_raw_reg : left_raw_reg;

    nrgw_scale u_scale (
        .raw    (scale_raw),
        .wide   (wide_reg),
        .gain   (gain_reg),
        .scaled (scale_out)
    );

    assign count     = {1'b0, div_res.quotient} + PHASE_W'(1);
    assign count_cap = (count > PHASE_W'(MAX_EMIT));
    assign load_out  = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign wc_wide   = WC_MAX_W'(wc_reg);

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        in_rate_next    = in_rate_reg;
        out_rate_next   = out_rate_reg;
        gain_next       = gain_reg;
        stereo_next     = stereo_reg;
        wide_next       = wide_reg;
        phase_next      = phase_reg;
        wc_next         = wc_reg;
        left_raw_next   = left_raw_reg;
        right_raw_next  = right_raw_reg;
        blk_end_next    = blk_end_reg;
        scale_sel_next  = scale_sel_reg;
        left_smp_next   = left_smp_reg;
        right_smp_next  = right_smp_reg;
        emit_total_next = emit_total_reg;
        emit_idx_next   = emit_idx_reg;
        capped_next     = capped_reg;
        out_valid_next  = out_valid_reg;
        left_out_next   = left_out_reg;
        right_out_next  = right_out_reg;
        ring_idx_next   = ring_idx_reg;
        run_last_next   = run_last_reg;
        out_cap_next    = out_cap_reg;

        // register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IN_RATE:  in_rate_next  = cfg_data;
                CFG_OUT_RATE: out_rate_next = cfg_data;
                CFG_GAIN:     gain_next     = cfg_data[GAIN_W-1:0];
                CFG_STEREO:   stereo_next   = cfg_data[0];
                CFG_WIDE:     wide_next     = cfg_data[0];
                default:      ;
            endcase
        end

        // result taken downstream
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    left_raw_next  = left_raw;
                    right_raw_next = right_raw;
                    blk_end_next   = block_end;
                    scale_sel_next = 1'b0;
                    if (acc_lt)
                        state_next = ST_DIV;
                    else
                        phase_next = block_end ? '0 : (phase_reg - {1'b0, orate});
                end
            end
            ST_DIV:
            begin
                if (!scale_sel_reg)
                begin
                    left_smp_next  = scale_out;
                    right_smp_next = scale_out;
                    scale_sel_next = 1'b1;
                end
                else if (stereo_reg)
                    right_smp_next = scale_out;
                if (div_res.done)
                begin
                    capped_next     = count_cap;
                    emit_total_next = count_cap ? EW'(MAX_EMIT) : count[EW-1:0];
                    emit_idx_next   = '0;
                    phase_next      = blk_end_reg ? '0 :
                                      {1'b0, ir - RATE_W'(1) - div_res.remainder};
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    left_out_next  = left_smp_reg;
                    right_out_next = right_smp_reg;
                    ring_idx_next  = wc_wide[IDX_W-1:0];
                    run_last_next  = (EW'(emit_idx_reg + EW'(1)) == emit_total_reg);
                    out_cap_next   = capped_reg;
                    wc_next        = (wc_reg == WC_W'(RING_DEPTH - 1)) ? '0 :
                                     wc_reg + WC_W'(1);
                    emit_idx_next  = emit_idx_reg + EW'(1);
                    if (EW'(emit_idx_reg + EW'(1)) == emit_total_reg)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            in_rate_reg    <= IN_RATE_RST;
            out_rate_reg   <= OUT_RATE_RST;
            gain_reg       <= GAIN_RST;
            stereo_reg     <= 1'b1;
            wide_reg       <= 1'b1;
            phase_reg      <= '0;
            wc_reg         <= '0;
            left_raw_reg   <= '0;
            right_raw_reg  <= '0;
            blk_end_reg    <= 1'b0;
            scale_sel_reg  <= 1'b0;
            left_smp_reg   <= '0;
            right_smp_reg  <= '0;
            emit_total_reg <= '0;
            emit_idx_reg   <= '0;
            capped_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_out_reg   <= '0;
            right_out_reg  <= '0;
            ring_idx_reg   <= '0;
            run_last_reg   <= 1'b0;
            out_cap_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            in_rate_reg    <= in_rate_next;
            out_rate_reg   <= out_rate_next;
            gain_reg       <= gain_next;
            stereo_reg     <= stereo_next;
            wide_reg       <= wide_next;
            phase_reg      <= phase_next;
            wc_reg         <= wc_next;
            left_raw_reg   <= left_raw_next;
            right_raw_reg  <= right_raw_next;
            blk_end_reg    <= blk_end_next;
            scale_sel_reg  <= scale_sel_next;
            left_smp_reg   <= left_smp_next;
            right_smp_reg  <= right_smp_next;
            emit_total_reg <= emit_total_next;
            emit_idx_reg   <= emit_idx_next;
            capped_reg     <= capped_next;
            out_valid_reg  <= out_valid_next;
            left_out_reg   <= left_out_next;
            right_out_reg  <= right_out_next;
            ring_idx_reg   <= ring_idx_next;
            run_last_reg   <= run_last_next;
            out_cap_reg    <= out_cap_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign left_out   = left_out_reg;
    assign right_out  = right_out_reg;
    assign ring_index = ring_idx_reg;
    assign run_last   = run_last_reg;
    assign capped     = out_cap_reg;

    // Checks
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result loaded outside the emit state");

    a_capped_full_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && capped_reg) |-> (emit_total_reg == EW'(MAX_EMIT)))
        else $error("capped item without a full run of results");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((emit_idx_reg < emit_total_reg) && (emit_total_reg != '0)))
        else $error("emit index past the run length");

endmodule

`default_nettype wire
